// File: hw/rtl/vmt_pkg.sv
// vmt_pkg: shared types and constants for the vertex matrix transform block
// no dependencies; imported by vertex_matrix_transform_top and its testbench

package vmt_pkg;

    localparam int VAL_W     = 32;             // one Q-format component
    localparam int LANES     = 4;              // matrix rows and vector terms
    localparam int PROD_W    = 2 * VAL_W;      // exact coefficient * component
    localparam int SUM_W     = PROD_W + 2;     // exact sum of four products
    localparam int DATA_W    = LANES * VAL_W;  // packed vector on tdata
    localparam int MODE_W    = 2;
    localparam int ROW_W     = 2;
    localparam int IN_USER_W = MODE_W + ROW_W; // mode, then row index

    typedef enum logic [MODE_W-1:0] {
        MODE_LOAD   = 2'd0,
        MODE_XFORM4 = 2'd1,
        MODE_XFORM3 = 2'd2
    } t_mode;

    typedef logic signed [VAL_W-1:0]  t_val;
    typedef logic signed [PROD_W-1:0] t_prod;
    typedef logic signed [SUM_W-1:0]  t_sum;

endpackage

// File: hw/rtl/vertex_matrix_transform_top.sv
// path: an accepted transform request moves through the input, product, row-sum and output registers to m_axis
// throughput: one request per cycle unless m_axis back-pressure stalls the pipeline, loads and transforms mixed freely
// pipeline: input register, 16 products, row sums, round and saturate into the output register
// a load takes effect for every request accepted after it
// reset (synchronous, active low) empties the pipeline and sets the matrix to identity
// vertex_matrix_transform_top: 4x4 fixed-point matrix times vector, one pass per request
// depends on vmt_pkg

module vertex_matrix_transform_top #(
    parameter int FRAC_BITS = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // value_x, value_y, value_z, value_w (32 bits each)
    input  logic [vmt_pkg::DATA_W-1:0]     s_axis_tdata,
    // mode [1:0], row_index [3:2]
    input  logic [vmt_pkg::IN_USER_W-1:0]  s_axis_tuser,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // out_x, out_y, out_z, out_w (32 bits each)
    output logic [vmt_pkg::DATA_W-1:0]     m_axis_tdata,
    // saturated [0]
    output logic                           m_axis_tuser
);
    import vmt_pkg::*;

    localparam t_val ONE  = VAL_W'(1) << FRAC_BITS;
    localparam t_sum HALF = SUM_W'(1) << (FRAC_BITS - 1);

    // matrix
    t_val r_coef [LANES][LANES];

    // stage 1: input register
    logic            r_v1;
    t_mode           r_op1;
    logic [ROW_W-1:0] r_row1;
    t_val            r_vec1 [LANES];

    // stage 2: products
    logic  r_v2;
    logic  r_t3_2;
    t_prod r_prod [LANES][LANES];
    t_prod n_prod [LANES][LANES];

    // stage 3: row sums
    logic r_v3;
    logic r_t3_3;
    t_sum r_sum [LANES];
    t_sum n_sum [LANES];

    // stage 4: output register
    logic              r_v4;
    logic              r_out_t3;
    logic [DATA_W-1:0] r_out_data;
    logic              r_out_sat;
    logic [DATA_W-1:0] n_out_data;
    logic              n_out_sat;

    logic en1, en2, en3, en4;
    logic in_fire;
    logic in_keep;
    logic coef_wr;
    t_mode in_mode;

    // bubbles collapse, so a waiting result does not block an empty stage
    assign en4 = !r_v4 || m_axis_tready;
    assign en3 = !r_v3 || en4;
    assign en2 = !r_v2 || en3;
    assign en1 = !r_v1 || en2;

    assign s_axis_tready = en1;
    assign in_fire       = s_axis_tvalid && en1;
    assign in_mode       = t_mode'(s_axis_tuser[MODE_W-1:0]);
    // unused mode code is dropped on entry
    assign in_keep       = (in_mode == MODE_LOAD) || (in_mode == MODE_XFORM4)
                        || (in_mode == MODE_XFORM3);

    // a load writes as it leaves stage 1, after every older transform read the matrix
    assign coef_wr = r_v1 && en2 && (r_op1 == MODE_LOAD);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < LANES; r++) begin
                for (int c = 0; c < LANES; c++) begin
                    r_coef[r][c] <= (r == c) ? ONE : '0;
                end
            end
        end else if (coef_wr) begin
            for (int c = 0; c < LANES; c++) begin
                r_coef[r_row1][c] <= r_vec1[c];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (en1) begin
                r_v1 <= in_fire && in_keep;
            end
            if (en2) begin
                r_v2 <= r_v1 && (r_op1 != MODE_LOAD);
            end
            if (en3) begin
                r_v3 <= r_v2;
            end
            if (en4) begin
                r_v4 <= r_v3;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_op1  <= in_mode;
            r_row1 <= s_axis_tuser[IN_USER_W-1:MODE_W];
            for (int c = 0; c < LANES; c++) begin
                r_vec1[c] <= s_axis_tdata[c*VAL_W +: VAL_W];
            end
        end
        if (en2) begin
            r_t3_2 <= (r_op1 == MODE_XFORM3);
            r_prod <= n_prod;
        end
        if (en3) begin
            r_t3_3 <= r_t3_2;
            r_sum  <= n_sum;
        end
        if (en4) begin
            r_out_t3   <= r_t3_3;
            r_out_data <= n_out_data;
            r_out_sat  <= n_out_sat;
        end
    end

    // products; the w term drops out for a 3-vector
    always_comb begin
        t_val v;
        for (int r = 0; r < LANES; r++) begin
            for (int c = 0; c < LANES; c++) begin
                v = (c == LANES - 1 && r_op1 == MODE_XFORM3) ? '0 : r_vec1[c];
                n_prod[r][c] = PROD_W'(r_coef[r][c]) * PROD_W'(v);
            end
        end
    end

    always_comb begin
        for (int r = 0; r < LANES; r++) begin
            n_sum[r] = SUM_W'(r_prod[r][0]) + SUM_W'(r_prod[r][1])
                     + SUM_W'(r_prod[r][2]) + SUM_W'(r_prod[r][3]);
        end
    end

    // round half up, then clamp when the top bits are not a plain sign extension; out_w is 0 for a 3-vector
    always_comb begin
        t_sum rnd;
        logic ovf;
        n_out_sat  = 1'b0;
        n_out_data = '0;
        for (int r = 0; r < LANES; r++) begin
            rnd = (r_sum[r] + HALF) >>> FRAC_BITS;
            ovf = !((&rnd[SUM_W-1:VAL_W-1]) || !(|rnd[SUM_W-1:VAL_W-1]));
            if (r == LANES - 1 && r_t3_3) begin
                n_out_data[r*VAL_W +: VAL_W] = '0;
            end else if (ovf) begin
                n_out_sat = 1'b1;
                n_out_data[r*VAL_W +: VAL_W] = rnd[SUM_W-1] ? {1'b1, {(VAL_W-1){1'b0}}}
                                                            : {1'b0, {(VAL_W-1){1'b1}}};
            end else begin
                n_out_data[r*VAL_W +: VAL_W] = rnd[VAL_W-1:0];
            end
        end
    end

    assign m_axis_tvalid = r_v4;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_sat;

    a_w_zero_3vec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v4 && r_out_t3 |-> r_out_data[DATA_W-1 -: VAL_W] == '0)
        else $error("out_w not zero for a 3-vector transform");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_v4 |-> s_axis_tready)
        else $error("input stalled with an empty output register");

    a_identity_reset: assert property (@(posedge i_clk)
        i_rst_n && $past(!i_rst_n) |->
            r_coef[0][0] == ONE && r_coef[3][3] == ONE && r_coef[0][1] == '0)
        else $error("matrix not identity after reset");

    a_sat_clipped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v4 && r_out_sat |->
            r_out_data[VAL_W-2:0] == '1 || r_out_data[VAL_W-2:0] == '0
            || r_out_data[2*VAL_W-2 -: VAL_W-1] == '1
            || r_out_data[2*VAL_W-2 -: VAL_W-1] == '0
            || r_out_data[3*VAL_W-2 -: VAL_W-1] == '1
            || r_out_data[3*VAL_W-2 -: VAL_W-1] == '0
            || r_out_data[4*VAL_W-2 -: VAL_W-1] == '1
            || r_out_data[4*VAL_W-2 -: VAL_W-1] == '0)
        else $error("saturation flagged with no clipped component");

endmodule

// File: bench/vertex_matrix_transform_top_tb.sv
// testbench for vertex_matrix_transform_top: row loads, 4- and 3-term transforms, ignored requests
// a scoreboard class keeps its own matrix and checks every result; depends on vmt_pkg and the rtl
`timescale 1ns / 1ps

module vertex_matrix_transform_top_tb;
    import vmt_pkg::*;

    localparam int FRAC_BITS = 16;
    localparam int N_RANDOM = 1330;
    localparam int HOLD_CYCLES = 300;
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
    localparam t_val Q_ONE = 32'sh0001_0000;
    localparam t_val V_MAX = 32'sh7fff_ffff;
    localparam t_val V_MIN = 32'sh8000_0000;

    typedef struct {
        t_val comp[LANES];
        logic sat;
    } t_xform_result;

    class xform_scoreboard;
        t_val matrix[LANES*LANES];
        t_xform_result pending_q[$];
        int errors;
        int loads;
        int xforms;
        int ignored;
        int clipped;
        int checked;

        function new();
            for (int i = 0; i < LANES*LANES; i++) matrix[i] = (i % 5 == 0) ? Q_ONE : '0;
            errors = 0;
            loads = 0;
            xforms = 0;
            ignored = 0;
            clipped = 0;
            checked = 0;
        endfunction

        // exact sum of products, round half up, clamp to 32 bits
        function t_val row_dot(int r, logic [DATA_W-1:0] vec, int n, inout logic sat);
            t_sum acc;
            t_sum q;
            acc = '0;
            for (int c = 0; c < n; c++)
                acc = acc + t_sum'(matrix[r*LANES+c]) * t_sum'(t_val'(vec[c*VAL_W +: VAL_W]));
            acc = acc + (t_sum'(1) <<< (FRAC_BITS - 1));
            q = acc >>> FRAC_BITS;
            if (!(&q[SUM_W-1:VAL_W-1]) && (|q[SUM_W-1:VAL_W-1])) begin
                sat = 1'b1;
                return q[SUM_W-1] ? V_MIN : V_MAX;
            end
            return t_val'(q[VAL_W-1:0]);
        endfunction

        function void note_request(logic [MODE_W-1:0] mode, logic [ROW_W-1:0] row,
                                   logic [DATA_W-1:0] vec);
            t_xform_result res;
            logic sat;
            int n;
            case (mode)
                MODE_LOAD: begin
                    for (int c = 0; c < LANES; c++)
                        matrix[int'(row)*LANES+c] = t_val'(vec[c*VAL_W +: VAL_W]);
                    loads++;
                end
                MODE_XFORM4, MODE_XFORM3: begin
                    n = (mode == MODE_XFORM4) ? 4 : 3;
                    sat = 1'b0;
                    for (int r = 0; r < LANES; r++)
                        res.comp[r] = (r < n) ? row_dot(r, vec, n, sat) : '0;
                    res.sat = sat;
                    pending_q.push_back(res);
                    xforms++;
                    if (sat) clipped++;
                end
                default: ignored++;
            endcase
        endfunction

        function void check_result(logic [DATA_W-1:0] data, logic sat);
            string names[LANES] = '{"out_x", "out_y", "out_z", "out_w"};
            t_xform_result exp_res;
            t_val got;
            if (pending_q.size() == 0) begin
                $error("result with nothing pending: tdata=%h saturated=%b", data, sat);
                errors++;
                return;
            end
            exp_res = pending_q.pop_front();
            checked++;
            for (int c = 0; c < LANES; c++) begin
                got = t_val'(data[c*VAL_W +: VAL_W]);
                if (got !== exp_res.comp[c]) begin
                    $error("%s mismatch: expected %0d, actual %0d", names[c], exp_res.comp[c], got);
                    errors++;
                end
            end
            if (sat !== exp_res.sat) begin
                $error("saturated mismatch: expected %0b, actual %0b", exp_res.sat, sat);
                errors++;
            end
        endfunction

        function int pending();
            return pending_q.size();
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [DATA_W-1:0]     s_axis_tdata;
    logic [IN_USER_W-1:0]  s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [DATA_W-1:0]     m_axis_tdata;
    logic                  m_axis_tuser;

    xform_scoreboard sb;
    logic idle_on;
    logic hold_pending;

    vertex_matrix_transform_top #(
        .FRAC_BITS(FRAC_BITS)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tuser(m_axis_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #10_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    function automatic logic [DATA_W-1:0] pack4(t_val x, t_val y, t_val z, t_val w);
        return {w, z, y, x};
    endfunction

    // mostly small and medium fixed-point values so that many sums stay in range
    function automatic t_val rand_val();
        int k;
        k = $urandom_range(0, 9);
        if (k < 2) return t_val'($urandom);
        if (k < 7) return t_val'(int'($urandom_range(0, 2 << 20)) - (1 << 20));
        if (k < 9) return t_val'(int'($urandom_range(0, 2 << 24)) - (1 << 24));
        case ($urandom_range(0, 4))
            0: return V_MAX;
            1: return V_MIN;
            2: return Q_ONE;
            3: return -Q_ONE;
            default: return '0;
        endcase
    endfunction

    // called right after the clock rises; returns once the DUT has taken the request
    task automatic send_request(logic [MODE_W-1:0] mode, logic [ROW_W-1:0] row,
                                logic [DATA_W-1:0] data);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= data;
        s_axis_tuser <= {row, mode};
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_request(mode, row, data);
    endtask

    // receiver: checks results, stalls in bursts, and does one long hold-off on request
    initial begin
        int stall_left;
        int hold_left;
        logic hold_done;
        stall_left = 0;
        hold_left = 0;
        hold_done = 1'b0;
        m_axis_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && m_axis_tvalid && m_axis_tready)
                sb.check_result(m_axis_tdata, m_axis_tuser);
            if (hold_pending && !hold_done) begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end else if (idle_on && (($urandom_range(0, 5)) == 0)) begin
                stall_left = $urandom_range(1, 14) - 1;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    initial begin
        int waited;
        int r;
        logic [MODE_W-1:0] mode;
        sb = new();
        idle_on = 1'b1;
        hold_pending = 1'b0;
        i_rst_n <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata <= '0;
        s_axis_tuser <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // identity matrix, extremes pass through unchanged
        send_request(MODE_XFORM4, 2'd0, pack4(Q_ONE, -32'sh0002_8000, V_MAX, V_MIN));
        send_request(MODE_XFORM3, 2'd3, pack4('0, Q_ONE, -Q_ONE, V_MAX));
        // unused mode leaves the matrix alone
        send_request(MODE_UNUSED, 2'd0, pack4(V_MAX, V_MAX, V_MAX, V_MAX));
        send_request(MODE_XFORM4, 2'd1, pack4(Q_ONE, Q_ONE, Q_ONE, Q_ONE));
        // one lsb coefficient: half-lsb ties round toward plus infinity
        send_request(MODE_LOAD, 2'd0, pack4(32'sd1, '0, '0, '0));
        send_request(MODE_XFORM4, 2'd0, pack4(32'sh0000_8000, '0, '0, '0));
        send_request(MODE_XFORM4, 2'd0, pack4(-32'sh0000_8000, '0, '0, '0));
        send_request(MODE_XFORM4, 2'd0, pack4(32'sh0000_7fff, '0, '0, '0));
        send_request(MODE_XFORM3, 2'd0, pack4(-32'sh0001_8000, '0, '0, '0));
        // extreme rows drive both clamp directions
        send_request(MODE_LOAD, 2'd1, pack4(V_MAX, V_MAX, V_MAX, V_MAX));
        send_request(MODE_LOAD, 2'd2, pack4(V_MIN, V_MIN, V_MIN, V_MIN));
        send_request(MODE_LOAD, 2'd3, pack4(V_MAX, V_MIN, '0, Q_ONE));
        send_request(MODE_XFORM4, 2'd2, pack4(V_MAX, V_MAX, V_MAX, V_MAX));
        send_request(MODE_XFORM4, 2'd3, pack4(V_MIN, V_MIN, V_MIN, V_MIN));
        send_request(MODE_XFORM3, 2'd1, pack4(V_MAX, V_MIN, V_MAX, V_MIN));
        send_request(MODE_XFORM4, 2'd0, '0);
        // row 3 would clip but transform3 skips it
        send_request(MODE_LOAD, 2'd1, pack4('0, Q_ONE, '0, '0));
        send_request(MODE_LOAD, 2'd2, pack4('0, '0, Q_ONE, '0));
        send_request(MODE_LOAD, 2'd3, pack4(V_MAX, V_MAX, V_MAX, V_MAX));
        send_request(MODE_XFORM3, 2'd0, pack4(Q_ONE, Q_ONE, Q_ONE, V_MAX));
        send_request(MODE_XFORM4, 2'd0, pack4(Q_ONE, Q_ONE, Q_ONE, V_MAX));
        send_request(MODE_LOAD, 2'd3, pack4('0, '0, '0, Q_ONE));

        for (int i = 0; i < N_RANDOM; i++) begin
            if (i == N_RANDOM - 300) idle_on = 1'b0;
            // long receiver hold-off while requests keep coming
            if (i == 400) hold_pending = 1'b1;
            if (idle_on && ((i / 80) % 3 != 2) && ($urandom_range(0, 3) == 0)) begin
                s_axis_tvalid <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge i_clk);
            end
            r = $urandom_range(0, 19);
            if (r < 4) mode = MODE_LOAD;
            else if (r < 11) mode = MODE_XFORM4;
            else if (r < 18) mode = MODE_XFORM3;
            else mode = MODE_UNUSED;
            send_request(mode, ROW_W'($urandom_range(0, 3)),
                         pack4(rand_val(), rand_val(), rand_val(), rand_val()));
        end
        s_axis_tvalid <= 1'b0;

        waited = 0;
        while (sb.pending() != 0 && waited < 5000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (8) @(posedge i_clk);
        if (sb.pending() != 0) begin
            $error("%0d expected results never arrived", sb.pending());
            sb.errors++;
        end

        $display("covered %0d row loads, %0d transforms (%0d clipped), %0d unused-mode requests",
                 sb.loads, sb.xforms, sb.clipped, sb.ignored);
        $display("%0d results compared, %0d mismatches", sb.checked, sb.errors);
        if (sb.errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// File: filelist.f
hw/rtl/vmt_pkg.sv
hw/rtl/vertex_matrix_transform_top.sv
bench/vertex_matrix_transform_top_tb.sv
